[hdl/chacha20_random_generator_core_macros.svh]
// Assertion macros used by the checker file
`ifndef CHACHA20_RANDOM_GENERATOR_CORE_MACROS_SVH
`define CHACHA20_RANDOM_GENERATOR_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication outside reset
`define CC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/ccrng_pkg.sv]
// ----------------------------------------------------------------------------
// ccrng_pkg
// Types, constants and helpers for the ChaCha20 random generator core.
// ----------------------------------------------------------------------------
package ccrng_pkg;

   localparam int MAX_REQUEST_BYTES = 512;
   localparam int DOUBLE_ROUNDS     = 10;
   localparam int ROUND_W           = $clog2(2 * DOUBLE_ROUNDS + 1);

   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646e;
   localparam logic [31:0] SIGMA2 = 32'h79622d32;
   localparam logic [31:0] SIGMA3 = 32'h6b206574;

   typedef enum logic [1:0] {
      FUNC_SEED     = 2'd0,
      FUNC_RESEED   = 2'd1,
      FUNC_GENERATE = 2'd2,
      FUNC_UNUSED   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QR,
      ST_FINAL,
      ST_OUT,
      ST_REKEY
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] seed_word0;
      logic [63:0] seed_word1;
      logic [63:0] seed_word2;
      logic [63:0] seed_word3;
      logic        key_present;
      logic [63:0] nonce_value;
      logic        nonce_present;
      logic [9:0]  byte_count;
   } req_type;

   typedef struct packed {
      logic [63:0] random_word;
      logic [3:0]  valid_bytes;
      logic        last;
   } rsp_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
      rotl = (v << s) | (v >> (32 - s));
   endfunction

endpackage

[hdl/chacha20_random_generator_core.sv]
// ----------------------------------------------------------------------------
// chacha20_random_generator_core
// ChaCha20 random generator: seed, reseed and generate on one shared
// quarter-round unit.
// ----------------------------------------------------------------------------
// Usage: an item on req_* is seed, reseed or generate. Seed updates the key
// and nonce where their present bits are set and clears the block counter.
// Reseed runs one block and rekeys. Generate emits ceil(n/8) items on
// rsp_*, n saturated to 512 bytes; each 64-byte block runs ten double
// rounds (one quarter round per cycle on the shared unit, eight per double
// round), then the final add, then up to eight words, one per item. A full
// 512-byte request runs eight blocks. Only reseed and nonzero generate
// requests raise req_stall; it stays high after acceptance until the
// request is finished. The result register holds its item while rsp_stall
// is high; the block waits for it to be taken before issuing the next
// item. Reset clears key, nonce and counter to zero and drops rsp_valid.
// ----------------------------------------------------------------------------
module chacha20_random_generator_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ccrng_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ccrng_pkg::rsp_type  rsp_data
);
   import ccrng_pkg::*;

   state_type   state_ff, state_in;
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [63:0] key_ff [4];
   logic [63:0] key_in [4];
   logic [63:0] nonce_ff, nonce_in, ctr_ff, ctr_in;
   req_type     req_ff, req_in;
   logic [9:0]  left_ff, left_in;
   logic [2:0]  widx_ff, widx_in, qr_ff, qr_in;
   logic [ROUND_W-1:0] rnd_ff, rnd_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        accept;
   logic [3:0]  ia, ib, ic, id;
   logic [31:0] a1, d1, c1, b1, a2, d2, c2, b2;
   logic [31:0] init [16];
   logic [63:0] word, mask;
   logic [3:0]  vb;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
      for (int i = 0; i < 4; i++) begin
         init[4 + 2 * i] = key_ff[i][31:0];
         init[5 + 2 * i] = key_ff[i][63:32];
      end
      init[12] = ctr_ff[31:0];   init[13] = ctr_ff[63:32];
      init[14] = nonce_ff[31:0]; init[15] = nonce_ff[63:32];
   end

   // quarter-round index select: columns then diagonals
   always_comb begin
      ia = {2'b00, qr_ff[1:0]};
      ib = qr_ff[2] ? {2'b01, qr_ff[1:0] + 2'd1} : {2'b01, qr_ff[1:0]};
      ic = qr_ff[2] ? {2'b10, qr_ff[1:0] + 2'd2} : {2'b10, qr_ff[1:0]};
      id = qr_ff[2] ? {2'b11, qr_ff[1:0] + 2'd3} : {2'b11, qr_ff[1:0]};
   end

   // shared quarter-round unit
   always_comb begin
      a1 = w_ff[ia] + w_ff[ib];
      d1 = rotl(w_ff[id] ^ a1, 16);
      c1 = w_ff[ic] + d1;
      b1 = rotl(w_ff[ib] ^ c1, 12);
      a2 = a1 + b1;
      d2 = rotl(d1 ^ a2, 8);
      c2 = c1 + d2;
      b2 = rotl(b1 ^ c2, 7);
   end

   always_comb begin
      word = {w_ff[{widx_ff, 1'b1}], w_ff[{widx_ff, 1'b0}]};
      vb   = (left_ff > 10'd8) ? 4'd8 : left_ff[3:0];
      mask = (vb == 4'd8) ? '1 : ((64'd1 << {vb, 3'b000}) - 64'd1);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority case (func_type'(req_data.func))
                  FUNC_RESEED: state_in = ST_QR;
                  FUNC_GENERATE: if (req_data.byte_count != '0) state_in = ST_QR;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_QR:
            if (qr_ff == 3'd7 && rnd_ff == ROUND_W'(DOUBLE_ROUNDS - 1))
               state_in = ST_FINAL;
         ST_FINAL:
            state_in = (func_type'(req_ff.func) == FUNC_RESEED) ? ST_REKEY : ST_OUT;
         ST_OUT:
            if (!(rsp_valid_ff && rsp_stall)) begin
               if (left_ff <= 10'd8) state_in = ST_IDLE;
               else if (widx_ff == 3'd7) state_in = ST_QR;
            end
         ST_REKEY: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      w_in = w_ff;
      key_in = key_ff;
      nonce_in = nonce_ff;
      ctr_in = ctr_ff;
      req_in = req_ff;
      left_in = left_ff;
      widx_in = widx_ff;
      qr_in = qr_ff;
      rnd_in = rnd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            w_in = init;
            qr_in = '0;
            rnd_in = '0;
            widx_in = '0;
            if (accept) begin
               req_in = req_data;
               left_in = (req_data.byte_count > 10'(MAX_REQUEST_BYTES))
                  ? 10'(MAX_REQUEST_BYTES) : req_data.byte_count;
               if (func_type'(req_data.func) == FUNC_SEED) begin
                  if (req_data.key_present) begin
                     key_in[0] = req_data.seed_word0;
                     key_in[1] = req_data.seed_word1;
                     key_in[2] = req_data.seed_word2;
                     key_in[3] = req_data.seed_word3;
                  end
                  if (req_data.nonce_present) nonce_in = req_data.nonce_value;
                  ctr_in = '0;
               end
            end
         end
         ST_QR: begin
            w_in[ia] = a2; w_in[ib] = b2; w_in[ic] = c2; w_in[id] = d2;
            qr_in = qr_ff + 3'd1;
            if (qr_ff == 3'd7) rnd_in = rnd_ff + ROUND_W'(1);
         end
         ST_FINAL: begin
            for (int i = 0; i < 16; i++) w_in[i] = w_ff[i] + init[i];
            ctr_in = ctr_ff + 64'd1;
            widx_in = '0;
         end
         ST_OUT: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_in.random_word = word & mask;
               rsp_in.valid_bytes = vb;
               rsp_in.last = (left_ff <= 10'd8);
               left_in = left_ff - {6'd0, vb};
               widx_in = widx_ff + 3'd1;
               if (widx_ff == 3'd7) begin
                  w_in = init;
                  qr_in = '0;
                  rnd_in = '0;
               end
            end
         end
         ST_REKEY: begin
            key_in[0] = {w_ff[1], w_ff[0]} ^ req_ff.seed_word0;
            key_in[1] = {w_ff[3], w_ff[2]} ^ req_ff.seed_word1;
            key_in[2] = {w_ff[5], w_ff[4]} ^ req_ff.seed_word2;
            key_in[3] = {w_ff[7], w_ff[6]} ^ req_ff.seed_word3;
            if (req_ff.nonce_present) nonce_in = req_ff.nonce_value;
            ctr_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         nonce_ff <= '0;
         ctr_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         key_ff <= key_in;
         nonce_ff <= nonce_in;
         ctr_ff <= ctr_in;
      end
      w_ff <= w_in;
      req_ff <= req_in;
      left_ff <= left_in;
      widx_ff <= widx_in;
      qr_ff <= qr_in;
      rnd_ff <= rnd_in;
      rsp_ff <= rsp_in;
   end

endmodule

[hdl/ccrng_checker.sv]
// ----------------------------------------------------------------------------
// ccrng_checker
// Port-level checks for the ChaCha20 random generator core.
// ----------------------------------------------------------------------------
`include "chacha20_random_generator_core_macros.svh"

module ccrng_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input ccrng_pkg::rsp_type rsp_data
);
   import ccrng_pkg::*;

   `CC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled item changed")
   `CC_ASSERT_IMP(a_vb_range, clock, reset, rsp_valid,
      rsp_data.valid_bytes != 4'd0 && rsp_data.valid_bytes <= 4'd8, "valid_bytes out of range")
   `CC_ASSERT_IMP(a_part_last, clock, reset, rsp_valid && rsp_data.valid_bytes != 4'd8,
      rsp_data.last, "partial word not last")
   `CC_ASSERT_IMP(a_busy_out, clock, reset, rsp_valid && !rsp_data.last,
      req_stall, "ready mid request")

endmodule

bind chacha20_random_generator_core ccrng_checker u_ccrng_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

[dv/tb_chacha20_random_generator_core.sv]
// ----------------------------------------------------------------------------
// tb_chacha20_random_generator_core
// Drives seed, reseed and generate items into the core and checks every
// random word against a ChaCha20 predictor kept alongside.
// ----------------------------------------------------------------------------
module tb_chacha20_random_generator_core;
   timeunit 1ns;
   timeprecision 1ps;
   import ccrng_pkg::*;

   class keystream_scoreboard;
      logic [63:0] key_words [4];
      logic [63:0] nonce;
      logic [63:0] counter;
      rsp_type     pending [$];
      int          errors;

      function new();
         foreach (key_words[i]) key_words[i] = '0;
         nonce = '0;
         counter = '0;
         errors = 0;
      endfunction

      function automatic logic [31:0] rot(logic [31:0] v, int s);
         return (v << s) | (v >> (32 - s));
      endfunction

      function automatic void qround(ref logic [31:0] w [16], input int a, int b, int c, int d);
         w[a] += w[b]; w[d] ^= w[a]; w[d] = rot(w[d], 16);
         w[c] += w[d]; w[b] ^= w[c]; w[b] = rot(w[b], 12);
         w[a] += w[b]; w[d] ^= w[a]; w[d] = rot(w[d], 8);
         w[c] += w[d]; w[b] ^= w[c]; w[b] = rot(w[b], 7);
      endfunction

      function automatic void chacha_block(output logic [63:0] blk [8]);
         logic [31:0] init [16];
         logic [31:0] w [16];
         init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
         for (int i = 0; i < 4; i++) begin
            init[4 + 2 * i] = key_words[i][31:0];
            init[5 + 2 * i] = key_words[i][63:32];
         end
         init[12] = counter[31:0];  init[13] = counter[63:32];
         init[14] = nonce[31:0];    init[15] = nonce[63:32];
         w = init;
         for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            qround(w, 0, 4, 8, 12);  qround(w, 1, 5, 9, 13);
            qround(w, 2, 6, 10, 14); qround(w, 3, 7, 11, 15);
            qround(w, 0, 5, 10, 15); qround(w, 1, 6, 11, 12);
            qround(w, 2, 7, 8, 13);  qround(w, 3, 4, 9, 14);
         end
         for (int i = 0; i < 8; i++)
            blk[i] = {w[2 * i + 1] + init[2 * i + 1], w[2 * i] + init[2 * i]};
         counter += 64'd1;
      endfunction

      function void note_request(req_type r);
         logic [63:0] blk [8];
         logic [63:0] seed [4];
         int count, done, vb;
         rsp_type e;
         seed = '{r.seed_word0, r.seed_word1, r.seed_word2, r.seed_word3};
         case (func_type'(r.func))
            FUNC_SEED: begin
               if (r.key_present) key_words = seed;
               if (r.nonce_present) nonce = r.nonce_value;
               counter = '0;
            end
            FUNC_RESEED: begin
               chacha_block(blk);
               for (int i = 0; i < 4; i++) key_words[i] = blk[i] ^ seed[i];
               if (r.nonce_present) nonce = r.nonce_value;
               counter = '0;
            end
            FUNC_GENERATE: begin
               count = (r.byte_count > MAX_REQUEST_BYTES) ? MAX_REQUEST_BYTES : r.byte_count;
               done = 0;
               while (done < count) begin
                  vb = (count - done > 8) ? 8 : count - done;
                  if (done % 64 == 0) chacha_block(blk);
                  e.random_word = blk[(done / 8) % 8];
                  if (vb < 8) e.random_word &= (64'd1 << (vb * 8)) - 64'd1;
                  e.valid_bytes = 4'(vb);
                  e.last = (done + vb >= count);
                  pending.push_back(e);
                  done += vb;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_word(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", got.random_word));
            return;
         end
         e = pending.pop_front();
         if (got.random_word !== e.random_word)
            report_mismatch($sformatf("random_word %h, want %h", got.random_word, e.random_word));
         if (got.valid_bytes !== e.valid_bytes)
            report_mismatch($sformatf("valid_bytes %0d, want %0d", got.valid_bytes, e.valid_bytes));
         if (got.last !== e.last)
            report_mismatch($sformatf("last %b, want %b", got.last, e.last));
      endfunction

      function void report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   keystream_scoreboard sb = new();
   bit quiet = 1'b0;

   chacha20_random_generator_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_data);

   // receiver stalls in bursts
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else begin
            n = $urandom_range(1, 15);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
      end
   end

   // valid stays high into the next call unless an idle burst follows
   task automatic send_request(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic req_type random_request(func_type f, int count);
      req_type r;
      r.func = f;
      r.seed_word0 = rand64(); r.seed_word1 = rand64();
      r.seed_word2 = rand64(); r.seed_word3 = rand64();
      r.key_present = 1'($urandom_range(0, 1));
      r.nonce_value = rand64();
      r.nonce_present = 1'($urandom_range(0, 1));
      r.byte_count = 10'(count);
      return r;
   endfunction

   initial begin
      req_type r;
      int k, count;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero state, extremes, every operation and odd lengths
      send_request(random_request(FUNC_GENERATE, 64));
      send_request(random_request(FUNC_GENERATE, 0));
      r = random_request(FUNC_SEED, 0);
      r.seed_word0 = '1; r.seed_word1 = '1; r.seed_word2 = '1; r.seed_word3 = '1;
      r.nonce_value = '1; r.key_present = 1'b1; r.nonce_present = 1'b1;
      send_request(r);
      send_request(random_request(FUNC_GENERATE, 1));
      send_request(random_request(FUNC_GENERATE, 7));
      send_request(random_request(FUNC_GENERATE, 9));
      send_request(random_request(FUNC_GENERATE, 65));
      send_request(random_request(FUNC_GENERATE, 1023));
      send_request(random_request(FUNC_GENERATE, 512));
      send_request(random_request(FUNC_GENERATE, 513));
      send_request(random_request(FUNC_UNUSED, 40));
      send_request(random_request(FUNC_GENERATE, 16));
      r = random_request(FUNC_RESEED, 0);
      r.nonce_present = 1'b1;
      send_request(r);
      send_request(random_request(FUNC_GENERATE, 24));
      r = random_request(FUNC_SEED, 0);
      r.key_present = 1'b0; r.nonce_present = 1'b0;
      send_request(r);
      send_request(random_request(FUNC_GENERATE, 100));
      r = random_request(FUNC_SEED, 0);
      r.seed_word0 = '0; r.seed_word1 = '0; r.seed_word2 = '0; r.seed_word3 = '0;
      r.nonce_value = '0; r.key_present = 1'b1; r.nonce_present = 1'b1;
      send_request(r);
      send_request(random_request(FUNC_GENERATE, 8));

      for (int i = 0; i < 270; i++) begin
         if (i == 230) quiet = 1'b1;
         k = $urandom_range(0, 19);
         if (k < 2) count = $urandom_range(0, 1023);
         else if (k < 4) count = $urandom_range(128, 512);
         else count = $urandom_range(1, 80);
         if (k < 13) send_request(random_request(FUNC_GENERATE, count));
         else if (k < 16) send_request(random_request(FUNC_SEED, count));
         else if (k < 19) send_request(random_request(FUNC_RESEED, count));
         else send_request(random_request(FUNC_UNUSED, count));
      end
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #30ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule

[filelist.f]
+incdir+hdl
hdl/ccrng_pkg.sv
hdl/chacha20_random_generator_core.sv
hdl/ccrng_checker.sv
dv/tb_chacha20_random_generator_core.sv
